@@ rtl/bba_pkg.sv @@
package bba_pkg;

  localparam int DefPoolOrder = 16;
  localparam int DefMinOrder  = 4;
  localparam int AddrW        = 16;
  localparam int SizeW        = 17;
  localparam int OrdW         = 5;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOINIT  = 2'd1,
    ST_BADSIZE = 2'd2,
    ST_NOSPACE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [SizeW-1:0] request_size;
    logic [AddrW-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] granted_address;
    logic [OrdW-1:0]  granted_order;
  } rsp_t;

endpackage

@@ rtl/bba_link_mem.sv @@
// One-port-write, one-port-read link memory with registered read data.
module bba_link_mem #(
  parameter int Depth = 4096,
  parameter int Width = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/buddy_block_allocator.sv @@
// Buddy allocator over a pool of 2^POOL_ORDER bytes in granules of 2^MIN_ORDER bytes.
// Send OP_INIT first; it sweeps the free-tag memory one granule a cycle, clearing all
// 2^(POOL_ORDER-MIN_ORDER) granules (4096 with the defaults). Allocate and free
// take one request at a time: each list unlink or push is a short read-modify-write
// sequence on the link and tag memories (one read port each), and split or merge
// repeats that per level, up to POOL_ORDER-MIN_ORDER levels.
module buddy_block_allocator #(
  parameter int POOL_ORDER = bba_pkg::DefPoolOrder,
  parameter int MIN_ORDER  = bba_pkg::DefMinOrder
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bba_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bba_pkg::rsp_t out_data
);
  import bba_pkg::*;

  localparam int NLev  = POOL_ORDER - MIN_ORDER + 1;
  localparam int GW    = POOL_ORDER - MIN_ORDER;
  localparam int LW    = (NLev > 1) ? $clog2(NLev) : 1;
  localparam int NGran = 1 << GW;
  localparam int PW    = GW + 1;            // granule index plus nil flag
  localparam int TW    = $clog2(NLev + 1);  // tag: 0 not free, else level+1

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_CHECK,
    S_A_SCAN, S_A_SPLIT,
    S_F_TAG, S_F_TAGW, S_F_BUD, S_F_BUDW, S_F_PUSH,
    S_U_RD, S_U_WAIT, S_U_FIX1, S_U_FIX2,
    S_P_RD, S_P_WAIT, S_P_WR, S_P_FIXN, S_P_DONE,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    RET_ALLOC, RET_SPLIT, RET_FMERGE, RET_FDONE
  } ret_t;

  state_t          state_r;
  ret_t            uret_r, pret_r;
  req_t            req_r;
  rsp_t            rsp_r;
  rsp_t            out_r;
  logic            out_valid_r;
  logic            ready_r;
  logic            pool_ok_r;
  logic [PW-1:0]   heads_r [NLev];
  logic [LW-1:0]   lv_r, k_r, plv_r;
  logic [GW-1:0]   g_r, ug_r, pg_r, clr_r;
  logic [PW-1:0]   un_r, up_r;

  // memories
  logic            nx_we, pv_we, tg_we;
  logic [GW-1:0]   nx_wa, pv_wa, tg_wa, nx_ra, pv_ra, tg_ra;
  logic [PW-1:0]   nx_wd, pv_wd, nx_rd, pv_rd;
  logic [TW-1:0]   tg_wd, tg_rd;
  logic [TW-1:0]   tag_mem [NGran];

  bba_link_mem #(.Depth(NGran), .Width(PW)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  bba_link_mem #(.Depth(NGran), .Width(PW)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));

  always_ff @(posedge clk) begin
    if (tg_we) begin
      tag_mem[tg_wa] <= tg_wd;
    end
    tg_rd <= tag_mem[tg_ra];
  end

  // ceil(log2(size)) raised to at least MIN_ORDER (no upper clamp), as a level
  function automatic logic [LW-1:0] level_of(input logic [SizeW-1:0] s);
    logic [SizeW-1:0] m;
    logic [LW-1:0]    r;
    m = s - SizeW'(1);
    r = '0;
    for (int b = 0; b < SizeW; b++) begin
      if (m[b] && b + 1 > MIN_ORDER) begin
        r = LW'(b + 1 - MIN_ORDER);
      end
    end
    return r;
  endfunction

  logic [SizeW-1:0] pool_bytes;
  assign pool_bytes = SizeW'(1) << POOL_ORDER;

  logic [LW-1:0] req_lv;
  assign req_lv = level_of(req_r.request_size);

  logic [GW-1:0] bud;
  assign bud = g_r ^ GW'(PW'(1) << lv_r);

  logic [PW-1:0] nil;
  assign nil = PW'(NGran);

  assign in_stall  = !ready_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = ug_r;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = ug_r;
    tg_we = 1'b0; tg_wa = '0; tg_wd = '0; tg_ra = ug_r;
    unique case (state_r)
      S_CLEAR: begin
        tg_we = 1'b1; tg_wa = clr_r;
      end
      S_F_TAG: tg_ra = g_r;
      S_F_BUD: tg_ra = bud;
      S_U_FIX1: begin
        if (!up_r[GW]) begin
          nx_we = 1'b1; nx_wa = up_r[GW-1:0]; nx_wd = un_r;
        end
        if (!un_r[GW]) begin
          pv_we = 1'b1; pv_wa = un_r[GW-1:0]; pv_wd = up_r;
        end
      end
      S_U_FIX2: begin
        tg_we = 1'b1; tg_wa = ug_r;
      end
      S_P_RD: tg_ra = pg_r;
      S_P_WR: begin
        nx_we = 1'b1; nx_wa = pg_r; nx_wd = heads_r[plv_r];
        pv_we = 1'b1; pv_wa = pg_r; pv_wd = nil;
        tg_we = 1'b1; tg_wa = pg_r; tg_wd = TW'(plv_r) + TW'(1);
      end
      S_P_FIXN: begin
        pv_we = 1'b1; pv_wa = ug_r; pv_wd = up_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b1;
      out_valid_r <= 1'b0;
      pool_ok_r   <= 1'b0;
      for (int i = 0; i < NLev; i++) heads_r[i] <= nil;
    end else begin
      if (state_r == S_RESP && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
        out_r       <= rsp_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && ready_r) begin
            req_r   <= in_data;
            ready_r <= 1'b0;
            rsp_r   <= '0;
            clr_r   <= '0;
            if (in_data.operation == OP_INIT) state_r <= S_CLEAR;
            else state_r <= S_CHECK;
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + GW'(1);
          if (clr_r == GW'(NGran - 1)) begin
            for (int i = 0; i < NLev; i++) heads_r[i] <= nil;
            pg_r   <= '0;
            plv_r  <= LW'(NLev - 1);
            pret_r <= RET_FDONE;
            rsp_r.granted_order <= OrdW'(POOL_ORDER);
            state_r <= S_P_WR;
          end
        end
        S_CHECK: begin
          lv_r <= req_lv;
          k_r  <= req_lv;
          g_r  <= GW'(req_r.block_address >> MIN_ORDER) & ~GW'((PW'(1) << req_lv) - PW'(1));
          if (req_r.operation == OP_NONE) state_r <= S_RESP;
          else if (!pool_ok_r) begin
            rsp_r.status <= ST_NOINIT; state_r <= S_RESP;
          end else if (req_r.request_size == '0 || req_r.request_size > pool_bytes) begin
            rsp_r.status <= ST_BADSIZE; state_r <= S_RESP;
          end else if (req_r.operation == OP_ALLOC) state_r <= S_A_SCAN;
          else state_r <= S_F_TAG;
        end
        S_A_SCAN: begin
          if (!heads_r[k_r][GW]) begin
            g_r   <= heads_r[k_r][GW-1:0];
            ug_r  <= heads_r[k_r][GW-1:0];
            uret_r <= RET_ALLOC;
            state_r <= S_U_RD;
          end else if (k_r == LW'(NLev - 1)) begin
            rsp_r.status <= ST_NOSPACE; state_r <= S_RESP;
          end else k_r <= k_r + LW'(1);
        end
        S_A_SPLIT: begin
          if (k_r == lv_r) begin
            rsp_r.granted_address <= AddrW'({g_r, {MIN_ORDER{1'b0}}});
            rsp_r.granted_order   <= OrdW'(lv_r) + OrdW'(MIN_ORDER);
            state_r <= S_RESP;
          end else begin
            pg_r   <= g_r;
            plv_r  <= k_r - LW'(1);
            pret_r <= RET_SPLIT;
            state_r <= S_P_RD;
          end
        end
        S_F_TAG: state_r <= S_F_TAGW;
        S_F_TAGW: begin
          if (tg_rd != '0) begin
            ug_r <= g_r; uret_r <= RET_FMERGE; state_r <= S_U_RD;
          end else state_r <= S_F_BUD;
        end
        S_F_BUD: begin
          if (lv_r == LW'(NLev - 1)) state_r <= S_F_PUSH;
          else state_r <= S_F_BUDW;
        end
        S_F_BUDW: begin
          if (tg_rd == TW'(lv_r) + TW'(1)) begin
            ug_r <= bud; uret_r <= RET_FMERGE;
            g_r  <= g_r & ~GW'(PW'(1) << lv_r);
            lv_r <= lv_r + LW'(1);
            state_r <= S_U_RD;
          end else state_r <= S_F_PUSH;
        end
        S_F_PUSH: begin
          pg_r <= g_r; plv_r <= lv_r; pret_r <= RET_FDONE;
          rsp_r.granted_address <= AddrW'({g_r, {MIN_ORDER{1'b0}}});
          rsp_r.granted_order   <= OrdW'(lv_r) + OrdW'(MIN_ORDER);
          state_r <= S_P_RD;
        end
        // unlink ug_r: read tag and links, then patch neighbors and head
        S_U_RD: state_r <= S_U_WAIT;
        S_U_WAIT: begin
          un_r <= nx_rd; up_r <= pv_rd;
          if (tg_rd == '0) state_r <= S_U_FIX2;
          else begin
            if (pv_rd[GW]) heads_r[LW'(tg_rd - TW'(1))] <= nx_rd;
            state_r <= S_U_FIX1;
          end
        end
        S_U_FIX1: state_r <= S_U_FIX2;
        S_U_FIX2: begin
          unique case (uret_r)
            RET_ALLOC: state_r <= S_A_SPLIT;
            RET_SPLIT: state_r <= S_P_WR;
            RET_FMERGE: state_r <= S_F_BUD;
            RET_FDONE: state_r <= S_P_WR;
          endcase
        end
        // push pg_r on level plv_r, withdrawing it first if already listed
        S_P_RD: state_r <= S_P_WAIT;
        S_P_WAIT: begin
          if (tg_rd != '0) begin
            ug_r <= pg_r; uret_r <= pret_r; state_r <= S_U_RD;
          end else state_r <= S_P_WR;
        end
        S_P_WR: begin
          heads_r[plv_r] <= {1'b0, pg_r};
          if (!heads_r[plv_r][GW]) begin
            // old head gets its prev link in a following write
            ug_r    <= heads_r[plv_r][GW-1:0];
            up_r    <= {1'b0, pg_r};
            un_r    <= nil;
            state_r <= S_P_FIXN;
          end else state_r <= S_P_DONE;
        end
        S_P_FIXN: state_r <= S_P_DONE;
        S_P_DONE: begin
          if (pret_r == RET_SPLIT) begin
            k_r <= k_r - LW'(1);
            g_r <= g_r + GW'(PW'(1) << (k_r - LW'(1)));
            state_r <= S_A_SPLIT;
          end else begin
            if (req_r.operation == OP_INIT) pool_ok_r <= 1'b1;
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            ready_r     <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
